FILE: src/bcrte_pkg.sv
package bcrte_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] DAYS_BASE    = 16'd10651;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [31:0] EPOCH_2000   = 32'd946684800;

    typedef struct packed {
        logic       ok;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } snap_t;

    function automatic logic [6:0] bcd_value(input logic [3:0] hi, input logic [3:0] lo);
        bcd_value = {3'b000, hi} * 7'd10 + {3'b000, lo};
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] month);
        case (month)
            4'd3:    month_start = 9'd0;
            4'd4:    month_start = 9'd31;
            4'd5:    month_start = 9'd61;
            4'd6:    month_start = 9'd92;
            4'd7:    month_start = 9'd122;
            4'd8:    month_start = 9'd153;
            4'd9:    month_start = 9'd184;
            4'd10:   month_start = 9'd214;
            4'd11:   month_start = 9'd245;
            4'd12:   month_start = 9'd275;
            4'd1:    month_start = 9'd306;
            4'd2:    month_start = 9'd337;
            default: month_start = 9'd0;
        endcase
    endfunction

endpackage

FILE: src/bcrte_front.sv
module bcrte_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        seconds_reg,
    input  logic [7:0]        minutes_reg,
    input  logic [7:0]        hours_reg,
    input  logic [7:0]        date_reg,
    input  logic [7:0]        month_reg,
    input  logic [7:0]        year_reg,
    input  logic              queue_full,
    output logic              push,
    output bcrte_pkg::snap_t  snap
);

    logic       link_ready_reg;
    logic       link_ready_next;
    logic [6:0] sec_v;
    logic [6:0] min_v;
    logic [6:0] hr_v;
    logic [6:0] hr_12;
    logic [6:0] day_v;
    logic [6:0] mon_v;
    logic [6:0] yr_v;
    logic [3:0] hr_hi;
    logic       sec_ok;
    logic       min_ok;
    logic       hr_ok;
    logic       day_ok;
    logic       mon_ok;
    logic       yr_ok;

    assign cfg_ready = 1'b1;
    assign link_ready_next = (cfg_valid && cfg_ready) ? cfg_data : link_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_ready_reg <= 1'b0;
        end
        else
        begin
            link_ready_reg <= link_ready_next;
        end
    end

    assign sec_v = bcrte_pkg::bcd_value({1'b0, seconds_reg[6:4]}, seconds_reg[3:0]);
    assign min_v = bcrte_pkg::bcd_value({1'b0, minutes_reg[6:4]}, minutes_reg[3:0]);
    assign day_v = bcrte_pkg::bcd_value({2'b00, date_reg[5:4]}, date_reg[3:0]);
    assign mon_v = bcrte_pkg::bcd_value({3'b000, month_reg[4]}, month_reg[3:0]);
    assign yr_v  = bcrte_pkg::bcd_value(year_reg[7:4], year_reg[3:0]);
    assign hr_hi = hours_reg[6] ? {3'b000, hours_reg[4]} : {2'b00, hours_reg[5:4]};
    assign hr_v  = bcrte_pkg::bcd_value(hr_hi, hours_reg[3:0]);

    assign sec_ok = (seconds_reg[3:0] <= 4'd9) && (sec_v <= 7'd59);
    assign min_ok = (minutes_reg[3:0] <= 4'd9) && (min_v <= 7'd59);
    assign day_ok = (date_reg[3:0] <= 4'd9) && (day_v >= 7'd1) && (day_v <= 7'd31);
    assign mon_ok = (month_reg[3:0] <= 4'd9) && (mon_v >= 7'd1) && (mon_v <= 7'd12);
    assign yr_ok  = (year_reg[7:4] <= 4'd9) && (year_reg[3:0] <= 4'd9);

    always_comb
    begin
        if (hours_reg[6])
        begin
            hr_ok = (hours_reg[3:0] <= 4'd9) && (hr_v >= 7'd1) && (hr_v <= 7'd12);
            hr_12 = ((hr_v == 7'd12) ? 7'd0 : hr_v) + (hours_reg[5] ? 7'd12 : 7'd0);
        end
        else
        begin
            hr_ok = (hours_reg[3:0] <= 4'd9) && (hr_v <= 7'd23);
            hr_12 = hr_v;
        end
    end

    assign snap.ok     = link_ready_reg && sec_ok && min_ok && hr_ok && day_ok && mon_ok && yr_ok;
    assign snap.year   = yr_v;
    assign snap.month  = mon_v[3:0];
    assign snap.day    = day_v[4:0];
    assign snap.hour   = hr_12[4:0];
    assign snap.minute = min_v[5:0];
    assign snap.second = sec_v[5:0];

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

endmodule

FILE: src/bcrte_queue.sv
module bcrte_queue
#(
    parameter int Depth = bcrte_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bcrte_pkg::snap_t  wr_data,
    output logic              full,
    input  logic              pop,
    output bcrte_pkg::snap_t  rd_data,
    output logic              empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST = AW'(Depth - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(Depth);

    bcrte_pkg::snap_t slots_reg [Depth];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/bcrte_back.sv
module bcrte_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  bcrte_pkg::snap_t  rd_data,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       epoch_seconds,
    output logic              valid_res
);

    logic        en;
    logic [6:0]  ys;
    logic [15:0] days_next;
    logic [16:0] sod_next;
    logic [31:0] prod_next;
    logic [31:0] epoch_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_ok_reg;
    logic [15:0] s1_days_reg;
    logic [16:0] s1_sod_reg;
    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic        s2_ok_reg;
    logic [31:0] s2_prod_reg;
    logic [16:0] s2_sod_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_ok_reg;
    logic [31:0] out_epoch_reg;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && !empty;

    assign ys = rd_data.year + {6'b000000, (rd_data.month > 4'd2)};
    assign days_next = bcrte_pkg::DAYS_BASE
                     + {9'b0, ys} * 16'd365
                     + {11'b0, 5'(({1'b0, ys} + 8'd3) >> 2)}
                     + {7'b0, bcrte_pkg::month_start(rd_data.month)}
                     + {11'b0, rd_data.day}
                     - 16'd1;
    assign sod_next = {12'b0, rd_data.hour} * 17'd3600
                    + {11'b0, rd_data.minute} * 17'd60
                    + {11'b0, rd_data.second};

    assign prod_next  = {16'b0, s1_days_reg} * {15'b0, bcrte_pkg::SECS_PER_DAY};
    assign epoch_next = s2_ok_reg ? s2_prod_reg + {15'b0, s2_sod_reg} : 32'd0;

    assign s1_valid_next  = en ? !empty : s1_valid_reg;
    assign s2_valid_next  = en ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = en ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg     <= rd_data.ok;
            s1_days_reg   <= days_next;
            s1_sod_reg    <= sod_next;
            s2_ok_reg     <= s1_ok_reg;
            s2_prod_reg   <= prod_next;
            s2_sod_reg    <= s1_sod_reg;
            out_ok_reg    <= s2_ok_reg;
            out_epoch_reg <= epoch_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign valid_res     = out_ok_reg;
    assign epoch_seconds = out_epoch_reg;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (epoch_seconds == 32'd0))
        else $error("Invalid result carries a non-zero epoch.");

    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (epoch_seconds >= bcrte_pkg::EPOCH_2000))
        else $error("Valid result lies before the year 2000.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en) |=> (s1_valid_reg && $stable(s1_days_reg)))
        else $error("First stage changed while the output was stalled.");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> s1_valid_reg)
        else $error("Word taken from the queue was lost.");
`endif

endmodule

FILE: src/bcd_clock_registers_to_epoch_top.sv
// Converts a snapshot of six BCD clock registers into seconds since 1970, one word per
// cycle while the output is not stalled. A snapshot is checked and decoded in the cycle
// it is accepted and written into a small queue (QueueDepth words); a three-stage
// arithmetic pipeline then produces the result, which passes from the queue through the
// s1 and s2 stage registers to the output register. The queue lets the input keep flowing
// while a result waits to be taken, until it fills. Invalid digits, out-of-range fields
// or a clear link_ready register give valid_res low with a zero epoch.
module bcd_clock_registers_to_epoch_top
#(
    parameter int QueueDepth = bcrte_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  seconds_reg,
    input  logic [7:0]  minutes_reg,
    input  logic [7:0]  hours_reg,
    input  logic [7:0]  date_reg,
    input  logic [7:0]  month_reg,
    input  logic [7:0]  year_reg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] epoch_seconds,
    output logic        valid_res
);

    bcrte_pkg::snap_t wr_snap;
    bcrte_pkg::snap_t rd_snap;
    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_empty;

    bcrte_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .seconds_reg (seconds_reg),
        .minutes_reg (minutes_reg),
        .hours_reg   (hours_reg),
        .date_reg    (date_reg),
        .month_reg   (month_reg),
        .year_reg    (year_reg),
        .queue_full  (queue_full),
        .push        (push),
        .snap        (wr_snap)
    );

    bcrte_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_snap),
        .full    (queue_full),
        .pop     (pop),
        .rd_data (rd_snap),
        .empty   (queue_empty)
    );

    bcrte_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_data       (rd_snap),
        .empty         (queue_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .epoch_seconds (epoch_seconds),
        .valid_res     (valid_res)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CLOCK_PERIOD = 12;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_PERCENT = 6;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
        logic [7:0] date;
        logic [7:0] month;
        logic [7:0] year;
    } regs_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic        ok;
    } stamp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  seconds_reg = 8'h00;
    logic [7:0]  minutes_reg = 8'h00;
    logic [7:0]  hours_reg = 8'h00;
    logic [7:0]  date_reg = 8'h00;
    logic [7:0]  month_reg = 8'h00;
    logic [7:0]  year_reg = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] epoch_seconds;
    logic        valid_res;

    stamp_t      pending_stamps[$];
    logic        link_on = 1'b0;
    bit          offering = 1'b0;
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    bcd_clock_registers_to_epoch_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .seconds_reg   (seconds_reg),
        .minutes_reg   (minutes_reg),
        .hours_reg     (hours_reg),
        .date_reg      (date_reg),
        .month_reg     (month_reg),
        .year_reg      (year_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .epoch_seconds (epoch_seconds),
        .valid_res     (valid_res)
    );

    always #(CLOCK_PERIOD / 2) clk = ~clk;

    function automatic bit decode_pair(input logic [7:0] v, output int unsigned n);
        n = 0;
        if (v[7:4] > 4'd9 || v[3:0] > 4'd9)
            return 1'b0;
        n = v[7:4] * 10 + v[3:0];
        return 1'b1;
    endfunction

    function automatic bit decode_hour(input logic [7:0] raw, output int unsigned h);
        h = 0;
        if (raw[6])
        begin
            if (!decode_pair({3'b000, raw[4:0]}, h) || h == 0 || h > 12)
                return 1'b0;
            h = h % 12 + (raw[5] ? 12 : 0);
            return 1'b1;
        end
        return decode_pair({2'b00, raw[5:0]}, h);
    endfunction

    function automatic stamp_t convert_snapshot(input regs_t r, input logic link);
        int unsigned second, minute, hour, day, mon, yr;
        int unsigned y, era, yoe, mp, doy, doe;
        longint unsigned total;
        stamp_t s;
        s = '0;
        if (!link)
            return s;
        if (!decode_pair({1'b0, r.seconds[6:0]}, second) ||
            !decode_pair({1'b0, r.minutes[6:0]}, minute) ||
            !decode_hour(r.hours, hour) ||
            !decode_pair({2'b00, r.date[5:0]}, day) ||
            !decode_pair({3'b000, r.month[4:0]}, mon) ||
            !decode_pair(r.year, yr))
            return s;
        if (mon < 1 || mon > 12 || day < 1 || day > 31 || hour > 23 ||
            minute > 59 || second > 59)
            return s;
        y = 2000 + yr - (mon <= 2 ? 1 : 0);
        era = y / 400;
        yoe = y - era * 400;
        mp = (mon > 2) ? mon - 3 : mon + 9;
        doy = (153 * mp + 2) / 5 + day - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        total = longint'(era) * 146097 + doe - 719468;
        total = total * 86400 + hour * 3600 + minute * 60 + second;
        if (total > 64'hFFFF_FFFF)
            return s;
        s.epoch = total[31:0];
        s.ok = 1'b1;
        return s;
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned n);
        return {4'(n / 10), 4'(n % 10)};
    endfunction

    function automatic regs_t random_snapshot();
        regs_t r;
        int unsigned pick;
        r.seconds = to_bcd($urandom_range(59));
        r.seconds[7] = 1'($urandom_range(1));
        r.minutes = to_bcd($urandom_range(59));
        r.minutes[7] = 1'($urandom_range(1));
        if ($urandom_range(1))
        begin
            r.hours = to_bcd($urandom_range(12, 1));
            r.hours[6] = 1'b1;
            r.hours[5] = 1'($urandom_range(1));
        end
        else
            r.hours = to_bcd($urandom_range(23));
        r.hours[7] = 1'($urandom_range(1));
        r.date = to_bcd($urandom_range(31, 1));
        r.date[7:6] = 2'($urandom_range(3));
        r.month = to_bcd($urandom_range(12, 1));
        r.month[7:5] = 3'($urandom_range(7));
        r.year = to_bcd($urandom_range(99));
        pick = $urandom_range(99);
        if (pick < 5)
            r = {$urandom(), 16'($urandom())};
        else if (pick < 20)
        begin
            case ($urandom_range(5))
                0: r.seconds = 8'($urandom());
                1: r.minutes = 8'($urandom());
                2: r.hours = 8'($urandom());
                3: r.date = 8'($urandom());
                4: r.month = 8'($urandom());
                default: r.year = 8'($urandom());
            endcase
        end
        return r;
    endfunction

    task automatic send_word(input regs_t r);
        if (!calm)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                if (offering)
                begin
                    in_valid <= 1'b0;
                    offering = 1'b0;
                end
                @(posedge clk);
            end
        end
        {seconds_reg, minutes_reg, hours_reg, date_reg, month_reg, year_reg} <= r;
        if (!offering)
            in_valid <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (pending_stamps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_link_ready(input logic value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        link_on = value;
    endtask

    task automatic send_random_words(input int count);
        repeat (count)
            send_word(random_snapshot());
    endtask

    task automatic test_link_down();
        write_link_ready(1'b0);
        send_word(48'h00_00_00_01_01_00);
        send_word(48'h59_59_23_31_12_99);
        send_random_words(4);
        wait_for_results();
        write_link_ready(1'b1);
    endtask

    task automatic test_corner_words();
        regs_t corner_words[$] = '{
            48'h00_00_00_01_01_00, 48'h59_59_23_31_12_99, 48'h00_00_52_15_06_24,
            48'h00_00_72_15_06_24, 48'h30_45_61_15_06_24, 48'h00_00_40_15_06_24,
            48'h00_00_53_15_06_24, 48'h00_00_4A_15_06_24, 48'h0A_00_10_15_06_24,
            48'h00_7A_10_15_06_24, 48'h00_00_10_15_06_A0, 48'h00_00_10_15_06_9A,
            48'hD9_A0_A3_C5_92_24, 48'h00_00_10_15_00_24, 48'h00_00_10_15_13_24,
            48'h00_00_10_15_1A_24, 48'h00_00_10_00_06_24, 48'h00_00_10_32_06_24,
            48'h00_00_10_2F_06_24, 48'h00_00_24_15_06_24, 48'h00_00_2A_15_06_24,
            48'h00_60_10_15_06_24, 48'h60_00_10_15_06_24, 48'h00_00_00_31_02_23,
            48'h00_00_00_29_02_24, 48'h00_00_00_30_02_00, 48'hFF_FF_FF_FF_FF_FF
        };
        foreach (corner_words[i])
            send_word(corner_words[i]);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        calm = 1'b1;
        hold_request = 1'b1;
        send_random_words(40);
        calm = 1'b0;
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        send_random_words(30);
        wait_for_results();
        send_random_words(30);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        send_random_words(400);
        wait_for_results();
        write_link_ready(1'b0);
        send_random_words(60);
        wait_for_results();
        write_link_ready(1'b1);
        send_random_words(100);
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || $urandom_range(99) >= IDLE_PERCENT;
    end

    always @(posedge clk)
    begin
        stamp_t wanted;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_stamps.push_back(convert_snapshot(
                    {seconds_reg, minutes_reg, hours_reg, date_reg, month_reg, year_reg},
                    link_on));
            if (out_valid && out_ready)
            begin
                if (pending_stamps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected word: epoch %0d valid %0b",
                                 epoch_seconds, valid_res);
                end
                else
                begin
                    wanted = pending_stamps.pop_front();
                    if (epoch_seconds !== wanted.epoch || valid_res !== wanted.ok)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("Mismatch: expected epoch %0d valid %0b, got epoch %0d valid %0b",
                                     wanted.epoch, wanted.ok, epoch_seconds, valid_res);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_link_down();
        test_corner_words();
        test_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_for_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_stamps.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
